[hw/rtl/line_atomic_log_fifo_top_assert.svh]
// Assertion macros for the line-atomic log FIFO.
// Used by lalf_ctrl; expects i_clk and i_rst_n in the including module.
`ifndef LINE_ATOMIC_LOG_FIFO_TOP_ASSERT_SVH
`define LINE_ATOMIC_LOG_FIFO_TOP_ASSERT_SVH

// Condition in this cycle implies consequence in the next cycle.
`define LALF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("lalf assertion failed");

// Condition implies consequence in the same cycle.
`define LALF_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("lalf assertion failed");

`endif

[hw/rtl/lalf_pkg.sv]
// Shared types, constants and helpers for the line-atomic log FIFO.
// No dependencies; used by lalf_ctrl, lalf_dpath and the top level.
`timescale 1ns / 1ps

package lalf_pkg;

    localparam int BUFFER_SIZE = 256;
    localparam int PTR_W       = $clog2(BUFFER_SIZE);
    localparam int FREE_W      = (PTR_W > 8) ? PTR_W : 8;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_READ  = 1'b1;

    typedef logic [PTR_W-1:0] t_ptr;

    // Controller to datapath commands.
    typedef struct packed {
        logic accept;   // take the input item, update ring state
        logic load;     // move staged result into the output register
    } t_cmd;

    function automatic t_ptr ptr_next(input t_ptr p);
        t_ptr r;
        if (p == t_ptr'(BUFFER_SIZE - 1)) begin
            r = '0;
        end else begin
            r = p + t_ptr'(1);
        end
        return r;
    endfunction

endpackage

[hw/rtl/lalf_ctrl.sv]
// Handshake controller for the line-atomic log FIFO.
// Depends on lalf_pkg and line_atomic_log_fifo_top_assert.svh.
`timescale 1ns / 1ps
`include "line_atomic_log_fifo_top_assert.svh"

module lalf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    output logic              o_valid,
    input  logic              i_stall,
    output lalf_pkg::t_cmd    o_cmd
);

    typedef enum logic [1:0] {
        ST_ACCEPT = 2'b01,
        ST_FETCH  = 2'b10
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_load_ok;
    logic   w_accept;
    logic   w_load;

    // Output slot is free or is being drained this cycle.
    assign w_load_ok = !r_out_valid || !i_stall;
    assign o_stall   = !((r_state == ST_ACCEPT) || ((r_state == ST_FETCH) && w_load_ok));
    assign w_accept  = i_valid && !o_stall;
    assign w_load    = (r_state == ST_FETCH) && w_load_ok;

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_ACCEPT: begin
                if (w_accept) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                if (w_load) begin
                    n_state = w_accept ? ST_FETCH : ST_ACCEPT;
                end
            end
            default: begin
                n_state = ST_ACCEPT;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (w_load) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_ACCEPT;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_cmd.accept = w_accept;
    assign o_cmd.load   = w_load;

    `LALF_ASSERT_NEXT(a_accept_to_fetch, w_accept, r_state == ST_FETCH)
    `LALF_ASSERT_NEXT(a_load_sets_valid, w_load, r_out_valid)
    `LALF_ASSERT_NEXT(a_drain_to_accept, w_load && !w_accept, r_state == ST_ACCEPT)

endmodule

[hw/rtl/lalf_dpath.sv]
// Ring buffer datapath: byte store, pointers, drop counter, result registers.
// Depends on lalf_pkg; driven by commands from lalf_ctrl.
`timescale 1ns / 1ps

module lalf_dpath (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lalf_pkg::t_cmd    i_cmd,
    input  logic              i_op,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_of_line,
    output logic              o_read_valid,
    output logic [7:0]        o_read_byte,
    output logic              o_line_committed,
    output logic              o_line_dropped,
    output logic              o_drop_report_valid,
    output logic [31:0]       o_drop_report,
    output logic [7:0]        o_free_bytes,
    output logic [31:0]       o_dropped_lines
);

    logic [7:0] r_mem [lalf_pkg::BUFFER_SIZE];
    logic [7:0] r_rd_data;

    lalf_pkg::t_ptr r_pend, n_pend;
    lalf_pkg::t_ptr r_commit, n_commit;
    lalf_pkg::t_ptr r_tail, n_tail;
    logic           r_disc, n_disc;
    logic [31:0]    r_drop, n_drop;

    // staged result of the accepted item
    logic           r_stg_rv, n_stg_rv;
    logic           r_stg_lc, n_stg_lc;
    logic           r_stg_ld, n_stg_ld;
    logic           r_stg_drv, n_stg_drv;
    logic [31:0]    r_stg_dr, n_stg_dr;

    // output register
    logic           r_o_rv;
    logic [7:0]     r_o_rb;
    logic           r_o_lc;
    logic           r_o_ld;
    logic           r_o_drv;
    logic [31:0]    r_o_dr;
    logic [7:0]     r_o_free;
    logic [31:0]    r_o_drop;

    logic                        w_full;
    logic                        w_we;
    logic                        w_re;
    lalf_pkg::t_ptr              w_used;
    logic [lalf_pkg::FREE_W-1:0] w_free;
    logic [7:0]                  w_free_sat;

    assign w_full = (lalf_pkg::ptr_next(r_pend) == r_tail);

    always_comb begin
        n_pend    = r_pend;
        n_commit  = r_commit;
        n_tail    = r_tail;
        n_disc    = r_disc;
        n_drop    = r_drop;
        n_stg_rv  = 1'b0;
        n_stg_lc  = 1'b0;
        n_stg_ld  = 1'b0;
        n_stg_drv = 1'b0;
        n_stg_dr  = '0;
        w_we      = 1'b0;
        w_re      = 1'b0;
        if (i_cmd.accept) begin
            if (i_op == lalf_pkg::OP_WRITE) begin
                if (!r_disc) begin
                    if (!w_full) begin
                        w_we   = 1'b1;
                        n_pend = lalf_pkg::ptr_next(r_pend);
                    end else begin
                        n_disc = 1'b1;
                    end
                end
                if (i_last_of_line) begin
                    if (n_disc) begin
                        // roll the line back
                        n_pend = r_commit;
                        if (r_drop != '1) begin
                            n_drop = r_drop + 32'd1;
                        end
                        n_disc   = 1'b0;
                        n_stg_ld = 1'b1;
                    end else begin
                        n_commit = n_pend;
                        n_stg_lc = 1'b1;
                    end
                end
            end else begin
                if (r_commit != r_tail) begin
                    n_stg_rv = 1'b1;
                    w_re     = 1'b1;
                    n_tail   = lalf_pkg::ptr_next(r_tail);
                end else if (r_drop != '0) begin
                    n_stg_drv = 1'b1;
                    n_stg_dr  = r_drop;
                    n_drop    = '0;
                end
            end
        end
    end

    // Byte store: one write or one registered read per item.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[r_pend] <= i_data_byte;
        end
        if (w_re) begin
            r_rd_data <= r_mem[r_tail];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend   <= '0;
            r_commit <= '0;
            r_tail   <= '0;
            r_disc   <= 1'b0;
            r_drop   <= '0;
        end else begin
            r_pend   <= n_pend;
            r_commit <= n_commit;
            r_tail   <= n_tail;
            r_disc   <= n_disc;
            r_drop   <= n_drop;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_stg_rv  <= n_stg_rv;
            r_stg_lc  <= n_stg_lc;
            r_stg_ld  <= n_stg_ld;
            r_stg_drv <= n_stg_drv;
            r_stg_dr  <= n_stg_dr;
        end
    end

    // Pointers already hold the post-item values when the result loads.
    // Truncated size constant makes the wrap exact for power-of-two rings.
    assign w_used = (r_pend >= r_tail) ? (r_pend - r_tail)
                  : (r_pend + lalf_pkg::t_ptr'(lalf_pkg::BUFFER_SIZE) - r_tail);
    assign w_free = lalf_pkg::FREE_W'(lalf_pkg::BUFFER_SIZE - 1)
                  - lalf_pkg::FREE_W'(w_used);
    assign w_free_sat = (w_free > lalf_pkg::FREE_W'(255)) ? 8'hFF : w_free[7:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_o_rv   <= r_stg_rv;
            r_o_rb   <= r_stg_rv ? r_rd_data : 8'h00;
            r_o_lc   <= r_stg_lc;
            r_o_ld   <= r_stg_ld;
            r_o_drv  <= r_stg_drv;
            r_o_dr   <= r_stg_dr;
            r_o_free <= w_free_sat;
            r_o_drop <= r_drop;
        end
    end

    assign o_read_valid        = r_o_rv;
    assign o_read_byte         = r_o_rb;
    assign o_line_committed    = r_o_lc;
    assign o_line_dropped      = r_o_ld;
    assign o_drop_report_valid = r_o_drv;
    assign o_drop_report       = r_o_dr;
    assign o_free_bytes        = r_o_free;
    assign o_dropped_lines     = r_o_drop;

endmodule

[hw/rtl/line_atomic_log_fifo_top.sv]
// Results: the result of an accepted item is staged, then loaded into the output register
//   once the output slot is free or draining; o_valid is high from then on until it is taken.
// Throughput: one item per cycle while the output side keeps up; the byte store
//   is read at the accept edge, so results leave through a one-slot output register.
// Reset (i_rst_n low, synchronous): ring pointers, line-discard flag, drop counter,
//   controller state and o_valid clear; the byte store is not cleared (no clearing pass).
`timescale 1ns / 1ps

module line_atomic_log_fifo_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input item channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_of_line,
    // result item channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_read_valid,
    output logic [7:0]  o_read_byte,
    output logic        o_line_committed,
    output logic        o_line_dropped,
    output logic        o_drop_report_valid,
    output logic [31:0] o_drop_report,
    output logic [7:0]  o_free_bytes,
    output logic [31:0] o_dropped_lines
);

    // Depends on lalf_pkg, lalf_ctrl and lalf_dpath.

    // Commands from the controller: accept updates ring state and starts the
    // store read, load moves the staged result into the output register.
    lalf_pkg::t_cmd w_cmd;

    lalf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (w_cmd)
    );

    // Ring datapath: writes go behind the tentative head, the last byte of
    // a line commits it or rolls it back and counts a drop.
    lalf_dpath u_dpath (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (w_cmd),
        .i_op                (i_op),
        .i_data_byte         (i_data_byte),
        .i_last_of_line      (i_last_of_line),
        .o_read_valid        (o_read_valid),
        .o_read_byte         (o_read_byte),
        .o_line_committed    (o_line_committed),
        .o_line_dropped      (o_line_dropped),
        .o_drop_report_valid (o_drop_report_valid),
        .o_drop_report       (o_drop_report),
        .o_free_bytes        (o_free_bytes),
        .o_dropped_lines     (o_dropped_lines)
    );

endmodule
